### design/ofd_pkg.sv
// ----------------------------------------------------------------------------
// ofd_pkg
// Shared types and constants for the octal fraction to decimal converter.
// ----------------------------------------------------------------------------
`default_nettype none

package ofd_pkg;

   // Number of octal digit cells in the chain
   localparam int MAX_OCTAL_DIGITS = 49;
   localparam int LOAD_POS_W       = $clog2(MAX_OCTAL_DIGITS + 1);
   localparam int CELL_IDX_W       = (MAX_OCTAL_DIGITS > 1) ? $clog2(MAX_OCTAL_DIGITS) : 1;

   // Request commands
   typedef enum logic [1:0] {
      CMD_CLEAR = 2'd0,
      CMD_LOAD  = 2'd1,
      CMD_EMIT  = 2'd2
   } command_type;

   // Controller state
   typedef enum logic {
      ST_IDLE = 1'b0,
      ST_RUN  = 1'b1
   } state_type;

   typedef struct packed {
      command_type command;
      logic [2:0]  octal_digit;
   } req_type;

   typedef struct packed {
      logic [3:0] decimal_digit;
      logic       last;
   } rsp_type;

   // Per-cell control from the controller
   typedef struct packed {
      logic       clear;
      logic       write;
      logic [2:0] digit;
   } cell_ctl_type;

   // Data handed from one cell to its more significant neighbor
   typedef struct packed {
      logic       token;
      logic [3:0] carry;
      logic       zero;
   } link_type;

endpackage

`default_nettype wire

### design/ofd_cell.sv
// ----------------------------------------------------------------------------
// ofd_cell
// One octal digit position. When the token arrives it multiplies its digit
// by ten, adds the incoming carry and hands the new carry to its neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module ofd_cell (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire ofd_pkg::cell_ctl_type ctl,
   input  wire ofd_pkg::link_type  link_in,
   output ofd_pkg::link_type       link_out
);

   logic [2:0]        digit_ff, digit_in;
   ofd_pkg::link_type link_ff, link_in_nx;
   logic [6:0]        prod;

   // digit * 10 + carry, at most 79
   assign prod = {1'b0, digit_ff, 3'b000} + {3'b000, digit_ff, 1'b0} + {3'b000, link_in.carry};

   always_comb begin
      digit_in = digit_ff;
      if (ctl.clear) begin
         digit_in = 3'd0;
      end else if (ctl.write) begin
         digit_in = ctl.digit;
      end else if (link_in.token) begin
         digit_in = prod[2:0];
      end
      link_in_nx.token = link_in.token;
      link_in_nx.carry = prod[6:3];
      link_in_nx.zero  = link_in.zero & (prod[2:0] == 3'd0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         digit_ff      <= 3'd0;
         link_ff.token <= 1'b0;
      end else begin
         digit_ff      <= digit_in;
         link_ff.token <= link_in_nx.token;
      end
      link_ff.carry <= link_in_nx.carry;
      link_ff.zero  <= link_in_nx.zero;
   end

   assign link_out = link_ff;

endmodule

`default_nettype wire

### design/octal_fraction_to_decimal.sv
// ----------------------------------------------------------------------------
// octal_fraction_to_decimal
// Exact conversion of an octal fraction into decimal digits, one per emit.
// ----------------------------------------------------------------------------
// Usage:
//   req channel carries a command and an octal digit. Clear empties the store,
//   load appends a digit (most significant first, ignored once 49 are held),
//   emit multiplies the stored fraction by ten and returns the integer part on
//   the rsp channel with a last flag that marks a fraction now zero.
//   Clear and load return nothing.
//   An emit's result is registered once the token has crossed the chain: a
//   token enters the least significant of the 49 digit cells at the accepting
//   edge and steps from cell to cell, carrying the times-ten carry, and the
//   edge after the most significant cell registers the result. The next
//   request is taken from the following cycle; no request is taken mid-emit.
//   The result sits in an output register; clear and load requests are still
//   taken while it waits. A new emit is held off until the waiting result is
//   taken, or is taken in the same cycle.
//   Reset (synchronous, active high) zeroes all digits and the load position
//   and drops rsp_valid.
// ----------------------------------------------------------------------------
`default_nettype none

module octal_fraction_to_decimal (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire logic            req_valid,
   output logic                 req_ready,
   input  wire ofd_pkg::req_type req_data,
   output logic                 rsp_valid,
   input  wire logic            rsp_ready,
   output ofd_pkg::rsp_type     rsp_data
);

   localparam int N = ofd_pkg::MAX_OCTAL_DIGITS;

   ofd_pkg::state_type          state_ff, state_in;
   logic [ofd_pkg::LOAD_POS_W-1:0] load_pos_ff, load_pos_in;
   logic                        rsp_valid_ff, rsp_valid_in;
   ofd_pkg::rsp_type            rsp_data_ff, rsp_data_in;

   logic                        req_fire;
   logic                        do_clear, do_load, do_emit;
   logic                        store_full;
   ofd_pkg::link_type           link [0:N];
   ofd_pkg::cell_ctl_type       ctl  [0:N-1];

   // Request decode
   assign req_fire   = req_valid & req_ready;
   assign do_clear   = req_fire & (req_data.command == ofd_pkg::CMD_CLEAR);
   assign do_load    = req_fire & (req_data.command == ofd_pkg::CMD_LOAD);
   assign do_emit    = req_fire & (req_data.command == ofd_pkg::CMD_EMIT);
   assign store_full = (load_pos_ff == ofd_pkg::LOAD_POS_W'(N));

   // Token enters at the least significant cell with no carry
   assign link[N].token = do_emit;
   assign link[N].carry = 4'd0;
   assign link[N].zero  = 1'b1;

   // Row of digit cells; cell 0 is the most significant
   for (genvar i = 0; i < N; i++) begin : g_cell
      assign ctl[i].clear = do_clear;
      assign ctl[i].write = do_load & ~store_full &
                            (load_pos_ff[ofd_pkg::CELL_IDX_W-1:0] ==
                             ofd_pkg::CELL_IDX_W'(i));
      assign ctl[i].digit = req_data.octal_digit;

      ofd_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .ctl      (ctl[i]),
         .link_in  (link[i+1]),
         .link_out (link[i])
      );
   end

   // Controller: next state, ready and result capture
   always_comb begin
      state_in     = state_ff;
      load_pos_in  = load_pos_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_ready;
      rsp_data_in  = rsp_data_ff;
      req_ready    = 1'b0;
      case (state_ff)
         ofd_pkg::ST_IDLE: begin
            req_ready = (req_data.command != ofd_pkg::CMD_EMIT) | ~rsp_valid_ff | rsp_ready;
            if (do_emit) begin
               state_in = ofd_pkg::ST_RUN;
            end
         end
         ofd_pkg::ST_RUN: begin
            if (link[0].token) begin
               state_in                  = ofd_pkg::ST_IDLE;
               rsp_valid_in              = 1'b1;
               rsp_data_in.decimal_digit = link[0].carry;
               rsp_data_in.last          = link[0].zero;
            end
         end
         default: begin
            state_in = ofd_pkg::ST_IDLE;
         end
      endcase
      if (do_clear) begin
         load_pos_in = '0;
      end else if (do_load & ~store_full) begin
         load_pos_in = load_pos_ff + ofd_pkg::LOAD_POS_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ofd_pkg::ST_IDLE;
         load_pos_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         load_pos_ff  <= load_pos_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

### design/ofd_checker.sv
// ----------------------------------------------------------------------------
// ofd_checker
// Port-level checks for the octal fraction to decimal converter.
// ----------------------------------------------------------------------------
`default_nettype none

module ofd_checker (
   input wire logic             clock,
   input wire logic             reset,
   input wire logic             req_valid,
   input wire logic             req_ready,
   input wire ofd_pkg::req_type req_data,
   input wire logic             rsp_valid,
   input wire logic             rsp_ready,
   input wire ofd_pkg::rsp_type rsp_data
);

   // Result holds until taken
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid & ~rsp_ready |=> rsp_valid & $stable(rsp_data))
      else $error("rsp dropped or changed while stalled");

   // Reset empties the output register
   a_rsp_reset: assert property (@(posedge clock)
      reset |=> ~rsp_valid)
      else $error("rsp_valid set after reset");

   // Decimal digits stay in range
   a_digit_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.decimal_digit <= 4'd9))
      else $error("decimal digit out of range");

   // An emit keeps the request side busy
   a_emit_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid & req_ready & (req_data.command == ofd_pkg::CMD_EMIT) |=> ~req_ready)
      else $error("request taken during emit");

   // A new result only appears at the end of an emit
   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(~req_ready))
      else $error("result without a running emit");

endmodule

bind octal_fraction_to_decimal ofd_checker u_ofd_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_ready (req_ready),
   .req_data  (req_data),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

`default_nettype wire
